// File: src/polar_offset_to_geo_waypoint_macros.svh
// ----------------------------------------------------------------------------
// polar_offset_to_geo_waypoint assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef POLAR_OFFSET_TO_GEO_WAYPOINT_MACROS_SVH
`define POLAR_OFFSET_TO_GEO_WAYPOINT_MACROS_SVH

// consequent must hold in the same cycle
`define POGW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define POGW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pogw_pkg.sv
// ----------------------------------------------------------------------------
// pogw_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package pogw_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int NSTG = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

  // pipeline depths of the units
  localparam int LSC  = NSTG + 1;
  localparam int LVC  = NSTG + 1;
  localparam int LSQ  = 31;
  localparam int LTOT = 2 * LSC + 2 * LVC + LSQ + 8;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_LAT     = 2'd0;
  localparam logic [1:0] REG_BASE_LON     = 2'd1;
  localparam logic [1:0] REG_BASE_HEADING = 2'd2;
  localparam logic [1:0] REG_STANDOFF     = 2'd3;

  typedef logic signed [33:0] trig_t;
  typedef logic signed [35:0] prod_t;
  typedef logic signed [37:0] vec_t;

  localparam trig_t       ONE_Q30    = 34'sd1073741824;
  localparam logic [29:0] INV_GAIN   = 30'd652032874;
  localparam logic [22:0] DIST_SCALE = 23'd7023702;

  typedef struct packed {
    logic [31:0] phi;
    logic [31:0] span;
    logic [31:0] hdg;
  } item_t;

  // rounded q1.30 product
  function automatic prod_t mulq(input trig_t a, input trig_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return p[65:30];
  endfunction

  function automatic logic [29:0] atan_at(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/pogw_front.sv
// ----------------------------------------------------------------------------
// pogw_front
// accepts items, forms absolute bearing and heading, two-entry queue
// ----------------------------------------------------------------------------
module pogw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         base_heading_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // rel_bearing [31:0], rel_distance [63:32], cam_offset [95:64]
  input  logic [95:0]         s_axis_tdata_i,
  input  logic                pop_i,
  output logic                hv_o,
  output pogw_pkg::item_t     head_o
);

  pogw_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  pogw_pkg::item_t wr_item;

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign hv_o            = (cnt_q != 2'd0);
  assign head_o          = mem_q[rd_q];

  // absolute bearing and camera heading
  always_comb begin
    wr_item.phi  = base_heading_i + s_axis_tdata_i[31:0];
    wr_item.span = s_axis_tdata_i[63:32];
    wr_item.hdg  = base_heading_i + s_axis_tdata_i[95:64];
  end

  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};

  // queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= wr_item;
  end

endmodule

// File: src/pogw_sincos.sv
// ----------------------------------------------------------------------------
// pogw_sincos
// pipelined rotation cordic, quadrant fold then one stage per iteration
// ----------------------------------------------------------------------------
module pogw_sincos (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         ang_i,
  output pogw_pkg::trig_t     cos_o,
  output pogw_pkg::trig_t     sin_o
);

  pogw_pkg::trig_t x_q [pogw_pkg::NSTG+1];
  pogw_pkg::trig_t y_q [pogw_pkg::NSTG+1];
  pogw_pkg::trig_t z_q [pogw_pkg::NSTG+1];
  logic            neg_q [pogw_pkg::NSTG+1];
  pogw_pkg::trig_t z0;
  pogw_pkg::trig_t zf;
  logic            negf;

  // fold into the right half plane
  always_comb begin
    z0   = pogw_pkg::trig_t'(signed'(ang_i));
    zf   = z0;
    negf = 1'b0;
    if (z0 > pogw_pkg::ONE_Q30) begin
      zf   = z0 - 34'sd2147483648;
      negf = 1'b1;
    end else if (z0 < -pogw_pkg::ONE_Q30) begin
      zf   = z0 + 34'sd2147483648;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= 34'sd652032874;
      y_q[0]   <= '0;
      z_q[0]   <= zf;
      neg_q[0] <= negf;
    end
  end

  // iteration stages
  for (genvar i = 1; i <= pogw_pkg::NSTG; i++) begin : g_stg
    localparam pogw_pkg::trig_t AT = pogw_pkg::trig_t'({4'b0, pogw_pkg::atan_at(i - 1)});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i] <= neg_q[i-1];
        if (!z_q[i-1][33]) begin
          x_q[i] <= x_q[i-1] - (y_q[i-1] >>> (i - 1));
          y_q[i] <= y_q[i-1] + (x_q[i-1] >>> (i - 1));
          z_q[i] <= z_q[i-1] - AT;
        end else begin
          x_q[i] <= x_q[i-1] + (y_q[i-1] >>> (i - 1));
          y_q[i] <= y_q[i-1] - (x_q[i-1] >>> (i - 1));
          z_q[i] <= z_q[i-1] + AT;
        end
      end
    end
  end

  assign cos_o = neg_q[pogw_pkg::NSTG] ? -x_q[pogw_pkg::NSTG] : x_q[pogw_pkg::NSTG];
  assign sin_o = neg_q[pogw_pkg::NSTG] ? -y_q[pogw_pkg::NSTG] : y_q[pogw_pkg::NSTG];

endmodule

// File: src/pogw_vec.sv
// ----------------------------------------------------------------------------
// pogw_vec
// pipelined vectoring cordic: atan2 angle and gain-scaled magnitude
// ----------------------------------------------------------------------------
module pogw_vec (
  input  logic                clk_i,
  input  logic                en_i,
  input  pogw_pkg::vec_t      x_i,
  input  pogw_pkg::vec_t      y_i,
  output logic [31:0]         ang_o,
  output pogw_pkg::vec_t      mag_o
);

  pogw_pkg::vec_t  x_q [pogw_pkg::NSTG+1];
  pogw_pkg::vec_t  y_q [pogw_pkg::NSTG+1];
  pogw_pkg::trig_t z_q [pogw_pkg::NSTG+1];
  logic            zero_q [pogw_pkg::NSTG+1];

  // zero vector detect and left half plane flip
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= 34'sd2147483648;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  // iteration stages
  for (genvar i = 1; i <= pogw_pkg::NSTG; i++) begin : g_stg
    localparam pogw_pkg::trig_t AT = pogw_pkg::trig_t'({4'b0, pogw_pkg::atan_at(i - 1)});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= zero_q[i-1];
        if (!y_q[i-1][37]) begin
          x_q[i] <= x_q[i-1] + (y_q[i-1] >>> (i - 1));
          y_q[i] <= y_q[i-1] - (x_q[i-1] >>> (i - 1));
          z_q[i] <= z_q[i-1] + AT;
        end else begin
          x_q[i] <= x_q[i-1] - (y_q[i-1] >>> (i - 1));
          y_q[i] <= y_q[i-1] + (x_q[i-1] >>> (i - 1));
          z_q[i] <= z_q[i-1] - AT;
        end
      end
    end
  end

  assign ang_o = zero_q[pogw_pkg::NSTG] ? 32'd0 : z_q[pogw_pkg::NSTG][31:0];
  assign mag_o = zero_q[pogw_pkg::NSTG] ? '0 : x_q[pogw_pkg::NSTG];

endmodule

// File: src/pogw_isqrt.sv
// ----------------------------------------------------------------------------
// pogw_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module pogw_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] v_i,
  output logic [30:0] root_o
);

  logic [61:0] rem_q [pogw_pkg::LSQ];
  logic [61:0] res_q [pogw_pkg::LSQ];

  // stage for the top bit pair
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if ({1'b0, v_i} >= (62'd1 << 60)) begin
        rem_q[0] <= {1'b0, v_i} - (62'd1 << 60);
        res_q[0] <= 62'd1 << 60;
      end else begin
        rem_q[0] <= {1'b0, v_i};
        res_q[0] <= '0;
      end
    end
  end

  // remaining bit pairs
  for (genvar j = 1; j < pogw_pkg::LSQ; j++) begin : g_stg
    localparam logic [61:0] BIT = 62'd1 << (2 * (pogw_pkg::LSQ - 1 - j));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[j-1] >= res_q[j-1] + BIT) begin
          rem_q[j] <= rem_q[j-1] - (res_q[j-1] + BIT);
          res_q[j] <= (res_q[j-1] >> 1) + BIT;
        end else begin
          rem_q[j] <= rem_q[j-1];
          res_q[j] <= res_q[j-1] >> 1;
        end
      end
    end
  end

  assign root_o = res_q[pogw_pkg::LSQ-1][30:0];

endmodule

// File: src/polar_offset_to_geo_waypoint.sv
// throughput: one item per cycle while results are taken, set by the fully pipelined cordic and square root units
// the back end stalls as a whole only while a finished result is not taken
// reset: queue and valid bits cleared, configuration registers cleared to zero
// ----------------------------------------------------------------------------
// polar_offset_to_geo_waypoint
// relative polar point to great-circle destination latitude, longitude, heading
// ----------------------------------------------------------------------------
`include "polar_offset_to_geo_waypoint_macros.svh"

module polar_offset_to_geo_waypoint (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // rel_bearing [31:0], rel_distance [63:32], cam_offset [95:64]
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // wp_lat [31:0], wp_lon [63:32], wp_heading [95:64]
  output logic [95:0] m_axis_tdata_o
);

  localparam int LT = pogw_pkg::LTOT;

  logic [31:0] base_lat_q, base_lon_q, base_heading_q, standoff_q;

  logic                en, pop, hv;
  pogw_pkg::item_t     head;
  logic [LT-1:0]       vld_q;
  logic                out_valid_q;
  logic [31:0]         lat_out_q, lon_out_q, hdg_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_lat_q     <= '0;
      base_lon_q     <= '0;
      base_heading_q <= '0;
      standoff_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pogw_pkg::REG_BASE_LAT:     base_lat_q     <= cfg_data_i;
        pogw_pkg::REG_BASE_LON:     base_lon_q     <= cfg_data_i;
        pogw_pkg::REG_BASE_HEADING: base_heading_q <= cfg_data_i;
        pogw_pkg::REG_STANDOFF:     standoff_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end
  pogw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .base_heading_i  (base_heading_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .pop_i           (pop),
    .hv_o            (hv),
    .head_o          (head)
  );

  // back end advances whenever the output register can take a result
  assign en  = !out_valid_q || m_axis_tready_i;
  assign pop = en && hv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LT-2:0], hv};
      out_valid_q <= vld_q[LT-1];
    end
  end

  // heading and distance side paths
  logic [31:0] hdg_q  [LT];
  logic [31:0] dist_q [pogw_pkg::LSC];
  always_ff @(posedge clk_i) begin
    if (en) begin
      hdg_q[0]  <= head.hdg;
      dist_q[0] <= head.span;
      for (int k = 1; k < LT; k++) hdg_q[k] <= hdg_q[k-1];
      for (int k = 1; k < pogw_pkg::LSC; k++) dist_q[k] <= dist_q[k-1];
    end
  end

  // sin and cos of vehicle heading and point bearing
  pogw_pkg::trig_t ch, sh, cp, sp;
  pogw_sincos u_sc_hdg (.clk_i(clk_i), .en_i(en), .ang_i(base_heading_q),
                        .cos_o(ch), .sin_o(sh));
  pogw_sincos u_sc_phi (.clk_i(clk_i), .en_i(en), .ang_i(head.phi),
                        .cos_o(cp), .sin_o(sp));

  // planar products
  pogw_pkg::prod_t p_sh_q, p_sp_q, p_ch_q, p_cp_q;
  pogw_pkg::trig_t so_t, di_t;
  assign so_t = pogw_pkg::trig_t'({2'b00, standoff_q});
  assign di_t = pogw_pkg::trig_t'({2'b00, dist_q[pogw_pkg::LSC-1]});
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sh_q <= pogw_pkg::mulq(so_t, sh);
      p_sp_q <= pogw_pkg::mulq(di_t, sp);
      p_ch_q <= pogw_pkg::mulq(so_t, ch);
      p_cp_q <= pogw_pkg::mulq(di_t, cp);
    end
  end

  // range and bearing of the offset
  pogw_pkg::vec_t east, north, raw;
  logic [31:0]    brg;
  assign east  = pogw_pkg::vec_t'(p_sh_q) + pogw_pkg::vec_t'(p_sp_q);
  assign north = pogw_pkg::vec_t'(p_ch_q) + pogw_pkg::vec_t'(p_cp_q);
  pogw_vec u_vec_rng (.clk_i(clk_i), .en_i(en), .x_i(north), .y_i(east),
                      .ang_o(brg), .mag_o(raw));

  // gain removal, then metres to angular distance
  logic [65:0] rng_prod;
  logic [63:0] del_prod;
  logic [35:0] range_q;
  logic [31:0] delta_q, brg_d_q, brg_e_q;
  assign rng_prod = 66'(raw[35:0]) * 66'(pogw_pkg::INV_GAIN) + 66'(32'd536870912);
  assign del_prod = 64'(range_q) * 64'(pogw_pkg::DIST_SCALE) + 64'(32'h8000_0000);
  always_ff @(posedge clk_i) begin
    if (en) begin
      range_q <= rng_prod[65:30];
      brg_d_q <= brg;
      delta_q <= del_prod[63:32];
      brg_e_q <= brg_d_q;
    end
  end

  // sin and cos of origin latitude, angular distance, bearing
  pogw_pkg::trig_t cl1, sl1, cd, sd, cb, sb;
  pogw_sincos u_sc_lat (.clk_i(clk_i), .en_i(en), .ang_i(base_lat_q),
                        .cos_o(cl1), .sin_o(sl1));
  pogw_sincos u_sc_del (.clk_i(clk_i), .en_i(en), .ang_i(delta_q),
                        .cos_o(cd), .sin_o(sd));
  pogw_sincos u_sc_brg (.clk_i(clk_i), .en_i(en), .ang_i(brg_e_q),
                        .cos_o(cb), .sin_o(sb));

  // spherical products, one multiply level per stage
  pogw_pkg::prod_t t1_g_q, t2_g_q, t3_g_q;
  pogw_pkg::trig_t cb_g_q, cl1_g_q, sl1_g_q, cd_g_q;
  pogw_pkg::prod_t t1_h_q, t4_h_q, t5_h_q;
  pogw_pkg::trig_t sl1_h_q, cd_h_q;
  pogw_pkg::prod_t t5_i_q;
  pogw_pkg::trig_t sl1_i_q, cd_i_q;
  logic signed [31:0] s_i_q, s_j_q, s_k_q;
  logic signed [34:0] s_sum;
  logic [60:0]     ss_j_q, v_k_q;
  pogw_pkg::prod_t t6_j_q, t5_j_q;
  pogw_pkg::trig_t cd_j_q;
  pogw_pkg::vec_t  xv_k_q, yv_k_q;
  logic signed [63:0] s_sq;

  assign s_sum = 35'(t1_h_q) + 35'(t4_h_q);
  assign s_sq  = 64'(s_i_q) * 64'(s_i_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_g_q  <= pogw_pkg::mulq(sl1, cd);
      t2_g_q  <= pogw_pkg::mulq(cl1, sd);
      t3_g_q  <= pogw_pkg::mulq(sb, sd);
      cb_g_q  <= cb;
      cl1_g_q <= cl1;
      sl1_g_q <= sl1;
      cd_g_q  <= cd;

      t4_h_q  <= pogw_pkg::mulq(pogw_pkg::trig_t'(t2_g_q), cb_g_q);
      t5_h_q  <= pogw_pkg::mulq(pogw_pkg::trig_t'(t3_g_q), cl1_g_q);
      t1_h_q  <= t1_g_q;
      sl1_h_q <= sl1_g_q;
      cd_h_q  <= cd_g_q;

      // sine of the destination latitude, clamped to unit range
      if (s_sum > 35'(pogw_pkg::ONE_Q30))       s_i_q <= 32'sd1073741824;
      else if (s_sum < -35'(pogw_pkg::ONE_Q30)) s_i_q <= -32'sd1073741824;
      else                                      s_i_q <= s_sum[31:0];
      t5_i_q  <= t5_h_q;
      sl1_i_q <= sl1_h_q;
      cd_i_q  <= cd_h_q;

      ss_j_q  <= s_sq[60:0];
      t6_j_q  <= pogw_pkg::mulq(sl1_i_q, pogw_pkg::trig_t'(s_i_q));
      s_j_q   <= s_i_q;
      t5_j_q  <= t5_i_q;
      cd_j_q  <= cd_i_q;

      v_k_q   <= (61'd1 << 60) - ss_j_q;
      xv_k_q  <= pogw_pkg::vec_t'(cd_j_q) - pogw_pkg::vec_t'(t6_j_q);
      yv_k_q  <= pogw_pkg::vec_t'(t5_j_q);
      s_k_q   <= s_j_q;
    end
  end

  // cosine of the destination latitude
  logic [30:0] root;
  pogw_isqrt u_isqrt (.clk_i(clk_i), .en_i(en), .v_i(v_k_q), .root_o(root));

  logic signed [31:0] s_dl_q [pogw_pkg::LSQ];
  pogw_pkg::vec_t     xv_dl_q [pogw_pkg::LSQ];
  pogw_pkg::vec_t     yv_dl_q [pogw_pkg::LSQ];
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_dl_q[0]  <= s_k_q;
      xv_dl_q[0] <= xv_k_q;
      yv_dl_q[0] <= yv_k_q;
      for (int k = 1; k < pogw_pkg::LSQ; k++) begin
        s_dl_q[k]  <= s_dl_q[k-1];
        xv_dl_q[k] <= xv_dl_q[k-1];
        yv_dl_q[k] <= yv_dl_q[k-1];
      end
    end
  end

  // latitude and longitude change
  logic [31:0]    lat_ang, dlon;
  pogw_pkg::vec_t lat_mag, lon_mag;
  pogw_vec u_vec_lat (.clk_i(clk_i), .en_i(en),
                      .x_i(pogw_pkg::vec_t'({7'b0, root})),
                      .y_i(pogw_pkg::vec_t'(s_dl_q[pogw_pkg::LSQ-1])),
                      .ang_o(lat_ang), .mag_o(lat_mag));
  pogw_vec u_vec_lon (.clk_i(clk_i), .en_i(en),
                      .x_i(xv_dl_q[pogw_pkg::LSQ-1]),
                      .y_i(yv_dl_q[pogw_pkg::LSQ-1]),
                      .ang_o(dlon), .mag_o(lon_mag));

  // output register with latitude clamp and longitude wrap
  logic signed [31:0] latv;
  assign latv = signed'(lat_ang);
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (latv > 32'sd1073741824)       lat_out_q <= 32'h4000_0000;
      else if (latv < -32'sd1073741824) lat_out_q <= 32'hC000_0000;
      else                              lat_out_q <= lat_ang;
      lon_out_q <= base_lon_q + dlon;
      hdg_out_q <= hdg_q[LT-1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {hdg_out_q, lon_out_q, lat_out_q};

  // checks
  `POGW_ASSERT_NOW(a_lat_range, out_valid_q,
    (signed'(lat_out_q) <= 32'sd1073741824) && (signed'(lat_out_q) >= -32'sd1073741824),
    "latitude outside the pole range")
  `POGW_ASSERT_NEXT(a_result_lands, en && vld_q[LT-1], out_valid_q,
    "finished item did not reach the output register")
  `POGW_ASSERT_NOW(a_queue_full, !s_axis_tready_o, hv,
    "input held off while the queue is empty")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// polar_offset_to_geo_waypoint testbench
// drives relative polar points over several origin settings and checks every
// waypoint against a bit-exact cordic predictor, with random gaps and stalls
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30    = 64'sd1073741824;
  localparam longint HALF   = 64'sd2147483648;
  localparam longint FULL   = 64'sd4294967296;
  localparam longint RND    = 64'sd536870912;
  localparam longint GAIN_R = 64'sd652032874;
  localparam longint KM_BA  = 64'sd7023702;
  localparam int     N_RAND = 1026;

  localparam longint ATAN_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] hdg;
  } waypoint_t;

  typedef struct packed {
    logic [31:0] rb;
    logic [31:0] span;
    logic [31:0] ih;
    logic [31:0] hdg;
  } point_row_t;

  // directed points, heading column valid for a zero base heading
  point_row_t point_rows [8] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h4000_0000, 32'h03E8_0000, 32'h4000_0000, 32'h4000_0000},
    '{32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000},
    '{32'hC000_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001},
    '{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h2000_0000, 32'h2710_0000, 32'h1234_5678, 32'h1234_5678},
    '{32'hE000_0000, 32'h0064_0000, 32'h0000_0000, 32'h0000_0000}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // rel_bearing [31:0], rel_distance [63:32], cam_offset [95:64]
  logic [95:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // wp_lat [31:0], wp_lon [63:32], wp_heading [95:64]
  logic [95:0] m_axis_tdata_o;

  // local copy of the origin registers
  logic [31:0] org_lat, org_lon, org_hdg, org_standoff;

  waypoint_t waypoint_q [$];
  int        n_mismatch;
  int        n_checked;
  bit        send_gaps;
  bit        recv_stalls;

  polar_offset_to_geo_waypoint u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // rotation cordic, angle folded into the right half plane
  function automatic void cordic_sincos(input logic [31:0] a, output longint c,
                                        output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(a);
    x = GAIN_R;
    y = 0;
    flip = 1'b0;
    if (z >= HALF) z -= FULL;
    if (z > Q30) begin
      z -= HALF;
      flip = 1'b1;
    end else if (z < -Q30) begin
      z += HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < pogw_pkg::NSTG; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // vectoring cordic: angle of (x, y) and gain-scaled magnitude
  function automatic logic [31:0] cordic_angle(input longint xa, input longint ya,
                                               output longint mag);
    longint z, dx, dy;
    z = 0;
    mag = 0;
    if (xa == 0 && ya == 0) return 32'd0;
    if (xa < 0) begin
      xa = -xa; ya = -ya; z = HALF;
    end
    for (int i = 0; i < pogw_pkg::NSTG; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya >= 0) begin
        xa += dx; ya -= dy; z += ATAN_TAB[i];
      end else begin
        xa -= dx; ya += dy; z -= ATAN_TAB[i];
      end
    end
    mag = xa;
    return z[31:0];
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + RND) >>> 30;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // great-circle destination of one relative point under the current origin
  function automatic waypoint_t predict_waypoint(input logic [31:0] rb,
                                                 input logic [31:0] span,
                                                 input logic [31:0] ih);
    waypoint_t w;
    logic [31:0] phi, brg, ang;
    longint ch, sh, cp, sp, east, north, mag, dummy;
    longint cl, sl, cd, sd, cb, sb, s, latv, yv, xv;
    longint unsigned rng, dlt;
    phi = org_hdg + rb;
    cordic_sincos(org_hdg, ch, sh);
    cordic_sincos(phi, cp, sp);
    east  = qmul(longint'(org_standoff), sh) + qmul(longint'(span), sp);
    north = qmul(longint'(org_standoff), ch) + qmul(longint'(span), cp);
    brg = cordic_angle(north, east, mag);
    rng = (longint'(mag) * 64'd652032874 + 64'd536870912) >> 30;
    dlt = (rng * 64'(KM_BA) + (64'd1 << 31)) >> 32;
    cordic_sincos(org_lat, cl, sl);
    cordic_sincos(dlt[31:0], cd, sd);
    cordic_sincos(brg, cb, sb);
    s = qmul(sl, cd) + qmul(qmul(cl, sd), cb);
    if (s > Q30) s = Q30;
    if (s < -Q30) s = -Q30;
    ang = cordic_angle(int_sqrt(longint'(Q30 * Q30 - s * s)), s, dummy);
    latv = longint'(ang);
    if (latv >= HALF) latv -= FULL;
    if (latv > Q30) latv = Q30;
    if (latv < -Q30) latv = -Q30;
    yv = qmul(qmul(sb, sd), cl);
    xv = cd - qmul(sl, s);
    w.lat = latv[31:0];
    w.lon = org_lon + cordic_angle(xv, yv, dummy);
    w.hdg = org_hdg + ih;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side backpressure
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!recv_stalls) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ($urandom_range(0, 99) < 75);
    end
  end

  // waypoint checker
  always @(posedge clk_i) begin
    waypoint_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tdata_o[95:64]};
      n_checked++;
      if (waypoint_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected waypoint lat=%h lon=%h hdg=%h", got.lat, got.lon, got.hdg);
      end else begin
        want = waypoint_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("waypoint mismatch: exp lat=%h lon=%h hdg=%h got lat=%h lon=%h hdg=%h",
                     want.lat, want.lon, want.hdg, got.lat, got.lon, got.hdg);
        end
      end
    end
  end

  // one point into the block, expectation queued on acceptance
  task automatic send_point(input logic [31:0] rb, input logic [31:0] span,
                            input logic [31:0] ih, input bit hdg_known,
                            input logic [31:0] hdg);
    waypoint_t w;
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ih, span, rb};
    do @(posedge clk_i); while (!s_axis_tready_o);
    w = predict_waypoint(rb, span, ih);
    if (hdg_known) w.hdg = hdg;
    waypoint_q = {waypoint_q, w};
  endtask

  // drain the pipeline, then load all four origin registers
  task automatic load_origin(input logic [31:0] lat, input logic [31:0] lon,
                             input logic [31:0] hdg, input logic [31:0] so);
    logic [31:0] vals [4];
    s_axis_tvalid_i <= 1'b0;
    while (waypoint_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    vals = '{lat, lon, hdg, so};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    org_lat = lat;
    org_lon = lon;
    org_hdg = hdg;
    org_standoff = so;
  endtask

  function automatic logic [31:0] rand_lat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h4000_0000;
    if (r == 1) return 32'hC000_0000;
    if (r == 2) return $urandom();
    return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] rand_wide(input logic [31:0] lim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(0, lim);
    return $urandom();
  endfunction

  // stimulus
  initial begin
    logic [31:0] span;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pogw_pkg::REG_BASE_LAT;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    n_mismatch = 0;
    n_checked = 0;
    org_lat = '0;
    org_lon = '0;
    org_hdg = '0;
    org_standoff = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset origin, origin at the north pole, origin beyond the pole, origin at the south pole
    foreach (point_rows[i])
      send_point(point_rows[i].rb, point_rows[i].span, point_rows[i].ih, 1'b1,
                 point_rows[i].hdg);
    load_origin(32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    foreach (point_rows[i])
      send_point(point_rows[i].rb, point_rows[i].span, point_rows[i].ih, 1'b0, '0);
    load_origin(32'h6000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    foreach (point_rows[i])
      send_point(point_rows[i].rb, point_rows[i].span, point_rows[i].ih, 1'b0, '0);
    load_origin(32'hC000_0000, 32'h8000_0000, 32'h4000_0000, 32'h0064_0000);
    for (int i = 0; i < 4; i++)
      send_point(point_rows[i].rb, point_rows[i].span, point_rows[i].ih, 1'b0, '0);

    // random phases, each with its own origin and idling mix
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 90 == 0) begin
        load_origin(rand_lat(), $urandom(), $urandom(), rand_wide(32'h0FFF_FFFF));
        send_gaps   = (n / 90) % 3 != 1;
        recv_stalls = (n / 90) % 3 != 2;
      end
      span = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h0FFF_FFFF) : $urandom();
      send_point($urandom(), span, $urandom(), 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (waypoint_q.size() != 0) @(posedge clk_i);
    repeat (pogw_pkg::LTOT + 20) @(posedge clk_i);
    $display("covered %0d waypoints over %0d origin settings incl. poles and extremes",
             n_checked, 4 + (N_RAND + 89) / 90);
    if (n_mismatch == 0 && waypoint_q.size() == 0) begin
      $display("polar_offset_to_geo_waypoint test passed");
    end else begin
      $display("mismatches: %0d", n_mismatch);
      $display("polar_offset_to_geo_waypoint test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d waypoints pending", waypoint_q.size());
    $display("polar_offset_to_geo_waypoint test failed");
    $finish;
  end

endmodule
